>>> hw/rtl/zbsf_pkg.sv
// Package for the z-buffer span fill shader: frame geometry, derived widths,
// payload structs, state encodings and divider request/response types.
// No dependencies.
package zbsf_pkg;

    localparam int FRAME_WIDTH  = 512;
    localparam int FRAME_HEIGHT = 512;

    localparam int COL_W     = $clog2(FRAME_WIDTH);
    localparam int CNT_W     = COL_W + 1;
    localparam int MEM_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // signed column math (ceil/floor of 20-bit fixed point, clamp to width)
    localparam int XC_W  = 14;
    // column offset in 1/256 units from the left edge
    localparam int OFF_W = (((COL_W + 8) > 19) ? (COL_W + 8) : 19) + 1;
    localparam int DIF_W = 25;
    localparam int NUM_W = OFF_W + DIF_W + 1;
    localparam int MAG_W = NUM_W - 1;
    localparam int DEN_W = 21;
    localparam int QW    = 36;
    localparam int NCH   = 4;

    localparam logic signed [23:0] DEPTH_FAR   = 24'sd8388607;
    localparam int                 SHADE_SCALE = 2 * 255;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0]         action;
        logic [8:0]         row;
        logic signed [19:0] x_left;
        logic signed [19:0] x_right;
        logic signed [23:0] depth_left;
        logic signed [23:0] depth_right;
        logic signed [15:0] red_left;
        logic signed [15:0] green_left;
        logic signed [15:0] blue_left;
        logic signed [15:0] red_right;
        logic signed [15:0] green_right;
        logic signed [15:0] blue_right;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] stored_depth;
        logic [7:0]         pixel_red;
        logic [7:0]         pixel_green;
        logic [7:0]         pixel_blue;
        logic [9:0]         pixels_written;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RB_RD,
        ST_RB_DATA,
        ST_SETUP,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PIX_RD,
        ST_PIX_CMP,
        ST_SHADE,
        ST_PIX_NEXT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        SH_IDLE,
        SH_SQ,
        SH_LIM,
        SH_TT,
        SH_CMP
    } t_shade_state;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic signed [QW-1:0] quo;
        logic [DEN_W-1:0]     rem;
    } t_div_rsp;

endpackage

>>> hw/rtl/zbsf_if.sv
// Valid/ready channel interfaces for span items and result transactions.
// Depends on zbsf_pkg.
interface zbsf_in_if import zbsf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

interface zbsf_out_if import zbsf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

>>> hw/rtl/zbsf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, floor semantics
// for a signed numerator and positive denominator. Depends on zbsf_pkg.
module zbsf_div import zbsf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(MAG_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [MAG_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]       rem_sh;
    logic                 ge;
    logic [DEN_W:0]       rem_sub;
    logic signed [QW-1:0] qm;
    logic                 rem_nz;

    assign rem_sh  = {r_rem, r_q[MAG_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MAG_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.mag;
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_q   <= {r_q[MAG_W-2:0], ge};
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign qm     = QW'(r_q);
    assign rem_nz = r_rem != '0;

    always_comb begin
        o_rsp.done = r_done;
        if (r_neg) begin
            o_rsp.quo = -qm - QW'(rem_nz);
            o_rsp.rem = rem_nz ? (r_den - r_rem) : '0;
        end else begin
            o_rsp.quo = qm;
            o_rsp.rem = r_rem;
        end
    end

endmodule

>>> hw/rtl/zbsf_shade.sv
// Normal-to-color unit: per channel round(255*n/|n|) clamped to 0..255 by an
// 8-step MSB-first search over exact integer compares. Depends on zbsf_pkg.
module zbsf_shade import zbsf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0][15:0]  i_norm,
    output logic              o_done,
    output logic [23:0]       o_color
);

    t_shade_state r_state;
    t_shade_state n_state;
    logic [2:0]   r_bit;
    logic         r_done;

    logic signed [15:0] r_n   [3];
    logic [31:0]        r_sq  [3];
    logic signed [24:0] r_m   [3];
    logic [47:0]        r_lim [3];
    logic [17:0]        r_t2  [3];
    logic [7:0]         r_c   [3];
    logic [33:0]        r_s;

    logic [7:0]  cand [3];
    logic [8:0]  tval [3];
    logic        pass [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cand[k] = r_c[k] | (8'd1 << r_bit);
            tval[k] = {cand[k], 1'b0} - 9'd1;
            pass[k] = (52'(r_t2[k]) * 52'(r_s)) <= 52'(r_lim[k]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SH_IDLE: if (i_start) n_state = SH_SQ;
            SH_SQ:   n_state = SH_LIM;
            SH_LIM:  n_state = SH_TT;
            SH_TT:   n_state = SH_CMP;
            SH_CMP:  n_state = (r_bit == 3'd0) ? SH_IDLE : SH_TT;
            default: n_state = SH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SH_IDLE;
            r_done  <= 1'b0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == SH_CMP) && (r_bit == 3'd0);
            if (r_state == SH_LIM) begin
                r_bit <= 3'd7;
            end else if (r_state == SH_CMP) begin
                r_bit <= r_bit - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            unique case (r_state)
                SH_IDLE: if (i_start) r_n[k] <= $signed(i_norm[k]);
                SH_SQ: begin
                    r_sq[k] <= 32'(32'(r_n[k]) * 32'(r_n[k]));
                    r_m[k]  <= 25'(25'(r_n[k]) * 25'(SHADE_SCALE));
                end
                SH_LIM: begin
                    r_lim[k] <= 48'(48'(r_m[k]) * 48'(r_m[k]));
                    r_c[k]   <= '0;
                end
                SH_TT:  r_t2[k] <= 18'(tval[k]) * 18'(tval[k]);
                SH_CMP: if (pass[k]) r_c[k] <= cand[k];
                default: ;
            endcase
        end
        if (r_state == SH_LIM) begin
            r_s <= 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]);
        end
    end

    assign o_done = r_done;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_color[23-8*k -: 8] = (r_n[k] > 16'sd0 && r_s != '0) ? r_c[k] : 8'd0;
        end
    end

endmodule

>>> hw/rtl/zbuffer_span_fill_shader_top.sv
// Z-buffer span fill shader top level: depth and color frame memories, span
// sequencer, slope setup and per-pixel depth test. Depends on zbsf_pkg,
// zbsf_if, zbsf_div and zbsf_shade.
//
// Usage: items enter on i_in (valid/ready); each gives exactly one result
// transaction on o_out. Action clear refills both memories, action draw fills
// one span of a row, action read returns the depth and color of one pixel.
// Only one item is in flight; i_in.ready is high while the sequencer is idle.
// Sequence per action:
//   clear : one memory entry written per cycle
//   read  : one registered read of both memories
//   draw  : setup divisions through the shared serial divider, then
//           per column a read and depth test, and for each column that passes
//           the depth test the shading search and a write.
// The two memories are single-write, single-read with a registered read;
// pixels are processed as read, compare, shade, write with no overlap.
// After reset the block sweeps both memories to their cleared values
// with i_in.ready low.
// The result sits in an output register; while the receiver stalls the next
// item can still be accepted and worked, finishing only once the register
// is free.
module zbuffer_span_fill_shader_top import zbsf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    zbsf_in_if.sink       i_in,
    zbsf_out_if.source    o_out
);

    t_state r_state;
    t_state n_state;

    t_in_item         r_item;
    logic             r_has_item;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [2:0]       r_j;
    logic [CNT_W-1:0] r_x;
    logic [CNT_W-1:0] r_hi;
    logic [CNT_W-1:0] r_count;
    logic [OFF_W-1:0] r_off;
    logic [DEN_W-2:0] r_dx;
    logic signed [OFF_W+DIF_W:0] r_prod;

    logic signed [DIF_W-1:0] r_vl  [NCH];
    logic signed [DIF_W-1:0] r_d   [NCH];
    logic signed [QW-1:0]    r_acc [NCH];
    logic [DEN_W-1:0]        r_rem [NCH];
    logic signed [QW-1:0]    r_qs  [NCH];
    logic [DEN_W-1:0]        r_rs  [NCH];

    logic signed [23:0] r_res_depth;
    logic [23:0]        r_res_color;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [23:0] depth_mem [MEM_DEPTH];
    logic [23:0] color_mem [MEM_DEPTH];
    logic signed [23:0] r_depth_rd;
    logic [23:0]        r_color_rd;

    logic              in_fire;
    logic              out_free;
    logic              c_we;
    logic [ADDR_W-1:0] c_waddr;
    logic [ADDR_W-1:0] c_raddr;
    logic [23:0]       c_wdepth;
    logic [23:0]       c_wcolor;
    logic              shade_start;
    logic              shade_done;
    logic [23:0]       shade_color;
    logic [2:0][15:0]  shade_norm;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic signed [20:0]      xl_e;
    logic signed [20:0]      xr_e;
    logic signed [20:0]      dx_s;
    logic signed [XC_W-1:0]  xs;
    logic signed [XC_W-1:0]  xe;
    logic signed [XC_W-1:0]  lo;
    logic signed [XC_W-1:0]  hi;
    logic signed [XC_W-1:0]  col;
    logic signed [XC_W+7:0]  off_s;
    logic                    row_ok;
    logic                    span_ok;
    logic                    rb_ok;
    logic [ADDR_W-1:0]       pix_addr;
    logic [ADDR_W-1:0]       rb_addr;
    logic                    clr_last;
    logic                    nearer;
    logic [1:0]              ch;
    logic signed [NUM_W-1:0] num;
    logic [CNT_W-1:0]        x_inc;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // span and read-back geometry
    assign xl_e    = {r_item.x_left[19], r_item.x_left};
    assign xr_e    = {r_item.x_right[19], r_item.x_right};
    assign dx_s    = xr_e - xl_e;
    assign xs      = XC_W'((xl_e + 21'sd255) >>> 8);
    assign xe      = XC_W'((xr_e + 21'sd255) >>> 8);
    assign lo      = (xs < 0) ? '0 : xs;
    assign hi      = (xe > XC_W'(FRAME_WIDTH)) ? XC_W'(FRAME_WIDTH) : xe;
    assign col     = XC_W'(xl_e >>> 8);
    assign off_s   = $signed({lo, 8'b0}) - (XC_W+8)'(xl_e);
    assign row_ok  = int'(r_item.row) < FRAME_HEIGHT;
    assign span_ok = row_ok && (dx_s > 0) && (hi > lo);
    assign rb_ok   = row_ok && (col >= 0) && (col < XC_W'(FRAME_WIDTH));
    assign pix_addr = ADDR_W'(r_item.row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(r_x);
    assign rb_addr  = ADDR_W'(r_item.row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(col);
    assign clr_last = r_clr_addr == ADDR_W'(MEM_DEPTH - 1);
    assign nearer   = $signed(r_acc[0][23:0]) < r_depth_rd;
    assign x_inc    = r_x + 1'b1;
    assign ch       = r_j[2:1];

    // divider numerator: 2*off*d + dx for a start value, 512*d for a step
    always_comb begin
        if (r_j[0]) begin
            num = NUM_W'(r_d[ch]) <<< 9;
        end else begin
            num = (NUM_W'(r_prod) <<< 1) + NUM_W'($signed({1'b0, r_dx}));
        end
        div_req.start = (r_state == ST_DIV_START);
        div_req.neg   = num[NUM_W-1];
        div_req.mag   = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        div_req.den   = {r_dx, 1'b0};
    end

    zbsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign shade_norm = {r_acc[3][15:0], r_acc[2][15:0], r_acc[1][15:0]};

    zbsf_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (shade_start),
        .i_norm  (shade_norm),
        .o_done  (shade_done),
        .o_color (shade_color)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:     if (clr_last) n_state = r_has_item ? ST_DONE : ST_IDLE;
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_in.data.action)
                        ACT_CLEAR: n_state = ST_CLEAR;
                        ACT_DRAW:  n_state = ST_SETUP;
                        ACT_READ:  n_state = ST_RB_RD;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_RB_RD:     n_state = rb_ok ? ST_RB_DATA : ST_DONE;
            ST_RB_DATA:   n_state = ST_DONE;
            ST_SETUP:     n_state = span_ok ? ST_MUL : ST_DONE;
            ST_MUL:       n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    priority if (r_j == 3'd7) n_state = ST_PIX_RD;
                    else if (!r_j[0])         n_state = ST_DIV_START;
                    else                      n_state = ST_MUL;
                end
            end
            ST_PIX_RD:    n_state = ST_PIX_CMP;
            ST_PIX_CMP:   n_state = nearer ? ST_SHADE : ST_PIX_NEXT;
            ST_SHADE:     if (shade_done) n_state = ST_PIX_NEXT;
            ST_PIX_NEXT:  n_state = (x_inc < r_hi) ? ST_PIX_RD : ST_DONE;
            ST_DONE:      if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        c_we        = 1'b0;
        c_waddr     = pix_addr;
        c_raddr     = pix_addr;
        c_wdepth    = DEPTH_FAR;
        c_wcolor    = '0;
        shade_start = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                c_we    = 1'b1;
                c_waddr = r_clr_addr;
            end
            ST_RB_RD:   c_raddr = rb_addr;
            ST_PIX_CMP: shade_start = nearer;
            ST_SHADE: begin
                c_we     = shade_done;
                c_wdepth = r_acc[0][23:0];
                c_wcolor = shade_color;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            depth_mem[c_waddr] <= c_wdepth;
        end
        r_depth_rd <= depth_mem[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            color_mem[c_waddr] <= c_wcolor;
        end
        r_color_rd <= color_mem[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_has_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_clr_addr <= '0;
                r_has_item <= 1'b1;
            end else if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == ST_DONE && out_free) begin
                r_has_item  <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_item      <= i_in.data;
                    r_res_depth <= '0;
                    r_res_color <= '0;
                    r_count     <= '0;
                    r_j         <= '0;
                    r_vl[0] <= DIF_W'(i_in.data.depth_left);
                    r_vl[1] <= DIF_W'(i_in.data.red_left);
                    r_vl[2] <= DIF_W'(i_in.data.green_left);
                    r_vl[3] <= DIF_W'(i_in.data.blue_left);
                    r_d[0]  <= DIF_W'(i_in.data.depth_right) - DIF_W'(i_in.data.depth_left);
                    r_d[1]  <= DIF_W'(i_in.data.red_right) - DIF_W'(i_in.data.red_left);
                    r_d[2]  <= DIF_W'(i_in.data.green_right) - DIF_W'(i_in.data.green_left);
                    r_d[3]  <= DIF_W'(i_in.data.blue_right) - DIF_W'(i_in.data.blue_left);
                end
            end
            ST_RB_DATA: begin
                r_res_depth <= r_depth_rd;
                r_res_color <= r_color_rd;
            end
            ST_SETUP: begin
                r_x   <= CNT_W'(lo);
                r_hi  <= CNT_W'(hi);
                r_off <= OFF_W'(off_s);
                r_dx  <= (DEN_W-1)'(dx_s);
            end
            ST_MUL: r_prod <= $signed({1'b0, r_off}) * r_d[ch];
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    r_j <= r_j + 3'd1;
                    if (r_j[0]) begin
                        r_qs[ch] <= div_rsp.quo;
                        r_rs[ch] <= div_rsp.rem;
                    end else begin
                        r_acc[ch] <= QW'(r_vl[ch]) + div_rsp.quo;
                        r_rem[ch] <= div_rsp.rem;
                    end
                end
            end
            ST_SHADE: if (shade_done) r_count <= r_count + 1'b1;
            ST_PIX_NEXT: begin
                r_x <= x_inc;
                for (int k = 0; k < NCH; k++) begin
                    logic [DEN_W:0] sum;
                    logic           wrap;
                    sum  = {1'b0, r_rem[k]} + {1'b0, r_rs[k]};
                    wrap = sum >= {1'b0, r_dx, 1'b0};
                    r_rem[k] <= wrap ? DEN_W'(sum - {1'b0, r_dx, 1'b0}) : DEN_W'(sum);
                    r_acc[k] <= r_acc[k] + r_qs[k] + QW'(wrap);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_data.stored_depth   <= r_res_depth;
                    r_out_data.pixel_red      <= r_res_color[23:16];
                    r_out_data.pixel_green    <= r_res_color[15:8];
                    r_out_data.pixel_blue     <= r_res_color[7:0];
                    r_out_data.pixels_written <= 10'(r_count);
                end
            end
            default: ;
        endcase
    end

endmodule
